// File: hw/rtl/utf8cpd_pkg.sv
package utf8cpd_pkg;

  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned PointWidth = 21;
  localparam int unsigned MaxResults = 3;
  localparam int unsigned HoldDepth  = 3;

  localparam logic [PointWidth-1:0] ErrPoint = 21'h00FFFF;

  typedef logic [ByteWidth-1:0]  byte_t;
  typedef logic [PointWidth-1:0] point_t;
  typedef logic [2:0]            len_t;

  // Sequence length from a lead byte; zero marks a byte that cannot lead.
  function automatic len_t lead_length(input byte_t b);
    len_t len;
    if (b inside {[8'h00:8'h7F]}) begin
      len = 3'd1;
    end else if (b inside {[8'hC0:8'hDF]}) begin
      len = 3'd2;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      len = 3'd3;
    end else if (b inside {[8'hF0:8'hF7]}) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // Joins the lead payload with the low six bits of each following byte.
  function automatic point_t decode_seq(input byte_t b0, input byte_t b1,
                                        input byte_t b2, input byte_t b3,
                                        input len_t len);
    point_t v;
    case (len)
      3'd1: v = {14'd0, b0[6:0]};
      3'd2: v = {10'd0, b0[4:0], b1[5:0]};
      3'd3: v = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4: v = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/utf8_code_point_decoder_core.sv
// An accepted byte reaches the master side through the input register, then the result buffer.
// Throughput: one byte per cycle while m_tready is high; a byte with n results holds the input
// until the three-entry result buffer, draining one code point per cycle, is at its last one.
// Reset (synchronous, active high) empties the input and result registers and drops any
// partly gathered sequence.
module utf8_code_point_decoder_core
  import utf8cpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [21] invalid, [23:22] zero
  output logic        m_tlast    // last_of_run
);

  // Input register.
  logic  in_valid;
  byte_t in_byte;
  logic  in_eot;

  // Open sequence.
  byte_t      pend [HoldDepth];
  logic [1:0] pend_count;
  len_t       need_len;

  // Result buffer, entry 0 is the head.
  point_t     res_cp   [MaxResults];
  logic       res_inv  [MaxResults];
  logic       res_last [MaxResults];
  logic [1:0] res_count;

  logic advance;
  logic out_take;

  // Values computed for the byte in the input register.
  point_t     new_cp   [MaxResults];
  logic       new_inv  [MaxResults];
  logic [1:0] new_count;
  logic       store;
  byte_t      pend_next [HoldDepth];
  logic [1:0] pend_count_next;
  len_t       need_len_next;

  assign out_take = m_tvalid && m_tready;
  assign advance  = in_valid && ((res_count == 2'd0) ||
                                 (res_count == 2'd1 && m_tready));
  assign s_tready = !in_valid || advance;

  always_comb begin
    byte_t b [7];
    len_t  n;
    len_t  len;
    len_t  cur;
    for (int i = 0; i < 7; i++) begin
      b[i] = '0;
    end
    for (int i = 0; i < HoldDepth; i++) begin
      if (2'(i) < pend_count) begin
        b[i] = pend[i];
      end
    end
    b[{1'b0, pend_count}] = in_byte;
    n = {1'b0, pend_count} + 3'd1;

    for (int i = 0; i < MaxResults; i++) begin
      new_cp[i]  = ErrPoint;
      new_inv[i] = 1'b1;
    end
    new_count       = 2'd0;
    store           = 1'b0;
    pend_next       = pend;
    pend_count_next = pend_count;
    need_len_next   = need_len;
    cur             = '0;
    len             = '0;

    if (!in_eot) begin
      len = (pend_count == 2'd0) ? lead_length(b[0]) : need_len;
      if (len == 3'd0) begin
        new_count = 2'd1;
      end else if (n >= len) begin
        new_cp[0]  = decode_seq(b[0], b[1], b[2], b[3], len);
        new_inv[0] = 1'b0;
        new_count  = 2'd1;
      end else begin
        store = 1'b1;
        for (int i = 0; i < HoldDepth; i++) begin
          pend_next[i] = b[i];
        end
        pend_count_next = n[1:0];
        need_len_next   = len;
      end
    end else begin
      // End of text: parse the held bytes and this byte again from the start.
      for (int s = 0; s < MaxResults; s++) begin
        if (cur < n) begin
          len = lead_length(b[cur]);
          if (len == 3'd0 || (cur + len) > n) begin
            new_cp[s]  = ErrPoint;
            new_inv[s] = 1'b1;
            cur        = cur + 3'd1;
          end else begin
            new_cp[s]  = decode_seq(b[cur], b[cur + 3'd1], b[cur + 3'd2], b[cur + 3'd3], len);
            new_inv[s] = 1'b0;
            cur        = cur + len;
          end
          new_count = new_count + 2'd1;
        end
      end
    end

    if (!store) begin
      for (int i = 0; i < HoldDepth; i++) begin
        pend_next[i] = '0;
      end
      pend_count_next = 2'd0;
      need_len_next   = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      pend_count <= 2'd0;
      need_len   <= 3'd0;
      res_count  <= 2'd0;
      for (int i = 0; i < HoldDepth; i++) begin
        pend[i] <= '0;
      end
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
        in_byte  <= s_tdata;
        in_eot   <= s_tlast;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        pend       <= pend_next;
        pend_count <= pend_count_next;
        need_len   <= need_len_next;
        res_count  <= new_count;
        for (int i = 0; i < MaxResults; i++) begin
          res_cp[i]   <= new_cp[i];
          res_inv[i]  <= new_inv[i];
          res_last[i] <= (2'(i) + 2'd1 == new_count);
        end
      end else if (out_take) begin
        res_count <= res_count - 2'd1;
        for (int i = 0; i < MaxResults - 1; i++) begin
          res_cp[i]   <= res_cp[i + 1];
          res_inv[i]  <= res_inv[i + 1];
          res_last[i] <= res_last[i + 1];
        end
      end
    end
  end

  assign m_tvalid = (res_count != 2'd0);
  assign m_tdata  = {2'b00, res_inv[0], res_cp[0]};
  assign m_tlast  = res_last[0];

  // End of text always closes any open sequence.
  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    advance && in_eot |=> pend_count == 2'd0 && need_len == 3'd0)
    else $error("open sequence survived end of text");

  // An open sequence always lacks at least one byte.
  a_open_short: assert property (@(posedge clk) disable iff (rst)
    pend_count != 2'd0 |-> need_len > {1'b0, pend_count})
    else $error("held sequence already complete");

  // An error result always carries the replacement value.
  a_err_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[21] |-> m_tdata[20:0] == ErrPoint)
    else $error("invalid result without replacement value");

  // A result that is not the last of its byte has a successor in the buffer.
  a_run_follows: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> res_count >= 2'd2)
    else $error("run ends without last flag");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

import utf8cpd_pkg::*;

typedef struct packed {
  point_t point;
  logic   bad;
  logic   last;
} point_result_t;

class code_point_scoreboard;
  byte_t          held_bytes[3];
  int             held_cnt;
  int             open_len;
  byte_t          window[4];
  point_result_t  expected_points[$];
  int             mismatches;
  int             requests;

  function new();
    held_bytes = '{default: '0};
    held_cnt   = 0;
    open_len   = 0;
    mismatches = 0;
    requests   = 0;
  endfunction

  function int seq_bytes_for(byte_t b);
    if (b[7] == 1'b0) return 1;
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  // Lead payload followed by six bits from each later byte of the window.
  function point_t join_payload(int pos, int len);
    int unsigned v;
    int          i;
    case (len)
      1: v = 32'(window[pos] & 8'h7F);
      2: v = 32'(window[pos] & 8'h1F);
      3: v = 32'(window[pos] & 8'h0F);
      default: v = 32'(window[pos] & 8'h07);
    endcase
    for (i = 1; i < len; i++) begin
      v = (v << 6) | 32'(window[pos+i] & 8'h3F);
    end
    return v[20:0];
  endfunction

  function void push_point(point_t p, logic bad);
    point_result_t r;
    r.point = p;
    r.bad   = bad;
    r.last  = 1'b0;
    expected_points.push_back(r);
  endfunction

  function void note_byte(byte_t b, bit eot);
    int n;
    int i;
    int pos;
    int len;
    int first;
    requests++;
    n = 0;
    for (i = 0; i < held_cnt; i++) begin
      window[n] = held_bytes[i];
      n++;
    end
    window[n] = b;
    n++;
    first = expected_points.size();
    if (!eot) begin
      len = (held_cnt == 0) ? seq_bytes_for(window[0]) : open_len;
      if (len == 0) begin
        push_point(ErrPoint, 1'b1);
      end else if (n >= len) begin
        push_point(join_payload(0, len), 1'b0);
      end else begin
        for (i = 0; i < n; i++) begin
          held_bytes[i] = window[i];
        end
        held_cnt = n;
        open_len = len;
        return;
      end
    end else begin
      // End of text: everything held is parsed again from its first byte.
      pos = 0;
      while (pos < n && expected_points.size() - first < MaxResults) begin
        len = seq_bytes_for(window[pos]);
        if (len == 0 || pos + len > n) begin
          push_point(ErrPoint, 1'b1);
          pos++;
        end else begin
          push_point(join_payload(pos, len), 1'b0);
          pos += len;
        end
      end
    end
    held_bytes = '{default: '0};
    held_cnt   = 0;
    open_len   = 0;
    expected_points[expected_points.size()-1].last = 1'b1;
  endfunction

  function void report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function void check_point(logic [23:0] data, logic last);
    point_result_t want;
    if (expected_points.size() == 0) begin
      report($sformatf("unexpected code point %h last %b", data, last));
      return;
    end
    want = expected_points.pop_front();
    if (data[20:0] !== want.point || data[21] !== want.bad || data[23:22] !== 2'b00 ||
        last !== want.last) begin
      report($sformatf({"expected point %h invalid %b last %b, ",
                        "got point %h invalid %b pad %b last %b"},
                       want.point, want.bad, want.last, data[20:0], data[21], data[23:22], last));
    end
  endfunction
endclass

module tb_top;
  localparam int TotalItems = 130;
  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 100;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;

  code_point_scoreboard sb = new();

  int sent       = 0;
  int burst_left = 0;
  int idle_count = 0;

  // {end_of_text, byte}: plain ASCII extremes, overlong, surrogate, a valid U+FFFF,
  // the largest four-byte value, bad leads and truncations at end of text.
  logic [8:0] directed [26] = '{
    9'h000, 9'h07F, 9'h0C0, 9'h080, 9'h0ED, 9'h0A0, 9'h080, 9'h0EF, 9'h0BF, 9'h0BF,
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, 9'h080, 9'h0FF, 9'h0F8, 9'h0F0, 9'h041, 9'h1C3,
    9'h0E2, 9'h182, 9'h0F0, 9'h09F, 9'h098, 9'h180
  };

  utf8_code_point_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_byte(input byte_t b, input bit eot);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b, eot);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  task automatic send_sequence();
    int    len;
    int    cut;
    int    i;
    bit    ends;
    byte_t lead;
    byte_t b;
    len = $urandom_range(1, 4);
    case (len)
      1: lead = 8'($urandom_range(8'h00, 8'h7F));
      2: lead = 8'($urandom_range(8'hC0, 8'hDF));
      3: lead = 8'($urandom_range(8'hE0, 8'hEF));
      default: lead = 8'($urandom_range(8'hF0, 8'hF7));
    endcase
    cut = len;
    if (len > 1 && $urandom_range(0, 9) == 0) cut = $urandom_range(1, len - 1);
    ends = (cut < len) || ($urandom_range(0, 6) == 0);
    for (i = 0; i < cut; i++) begin
      if (i == 0) begin
        b = lead;
      end else if ($urandom_range(0, 9) == 0) begin
        b = 8'($urandom_range(0, 255));
      end else begin
        b = 8'h80 | 8'($urandom_range(0, 8'h3F));
      end
      send_byte(b, ends && (i == cut - 1));
    end
  endtask

  initial begin
    int i;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    burst_left = $urandom_range(1, 20);
    for (i = 0; i < 26; i++) begin
      send_byte(directed[i][7:0], directed[i][8]);
    end
    while (sent < TotalItems) begin
      if ($urandom_range(0, 99) < 80) begin
        send_sequence();
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
    end
    // Close any open text so that every request has produced its results.
    send_byte(8'($urandom_range(0, 8'h7F)), 1'b1);
    s_tvalid <= 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: switches between always ready, coin flips and a fixed pattern, and once
  // holds off long enough for the block to fill up and stall its input.
  initial begin
    int  cycle;
    int  mode;
    int  hold_left;
    bit  held_off;
    cycle     = 0;
    mode      = 0;
    hold_left = 0;
    held_off  = 1'b0;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_point(m_tdata, m_tlast);
      cycle++;
      if (cycle % 32 == 0) mode = $urandom_range(0, 2);
      if (!held_off && sb.requests >= 50) begin
        held_off  = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= (cycle % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_count <= 0;
      end else if (idle_count >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

endmodule
